>>> rtl/rav_pkg.sv
// shared types, constants and rounding helpers for the rotation align unit
`default_nettype none
package rav_pkg;

	localparam logic signed [31:0] ONE_Q30         = 32'sh4000_0000;
	localparam logic signed [32:0] NINE_TENTHS_Q30 = 33'sd966367642;
	localparam logic [31:0]        ONE_Q30_U       = 32'h4000_0000;

	typedef enum logic [1:0] {
		CASE_GENERAL   = 2'd0,
		CASE_IDENTITY  = 2'd1,
		CASE_HALF_TURN = 2'd2
	} align_case_t;

	// one classified request as it waits between front and back
	typedef struct packed {
		logic signed [32:0] a_x;
		logic signed [32:0] a_y;
		logic signed [32:0] a_z;
		logic [63:0]        sum;
		logic signed [31:0] cosv;
		align_case_t        kase;
	} axis_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// q4.60 to q2.30, round half up
	function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd536870912;
		return signed'(t[65:30]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
		if (x > 38'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (x < -38'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return signed'(x[31:0]);
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/rav_front.sv
// front part: cross and dot products, classification, axis squares
`default_nettype none
module rav_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic signed [31:0]  u_x,
	input  wire logic signed [31:0]  u_y,
	input  wire logic signed [31:0]  u_z,
	input  wire logic signed [31:0]  v_x,
	input  wire logic signed [31:0]  v_y,
	input  wire logic signed [31:0]  v_z,
	output logic                     out_valid,
	output rav_pkg::axis_item_t      out_item
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [63:0] p_yz_s1, p_zy_s1, p_zx_s1, p_xz_s1, p_xy_s1, p_yx_s1;
	logic signed [63:0] p_xx_s1, p_yy_s1, p_zz_s1;
	logic signed [31:0] u_x_s1, u_y_s1, u_z_s1;

	logic signed [31:0] c_x_s2, c_y_s2, c_z_s2, cos_s2;
	logic signed [31:0] u_x_s2, u_y_s2, u_z_s2;

	logic signed [32:0] a_x_s3, a_y_s3, a_z_s3;
	logic               nz_s3, cpos_s3;
	logic signed [31:0] cos_s3;

	logic [63:0]        sq_x_s4, sq_y_s4, sq_z_s4;
	logic signed [32:0] a_x_s4, a_y_s4, a_z_s4;
	logic               nz_s4, cpos_s4;
	logic signed [31:0] cos_s4;

	rav_pkg::axis_item_t item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// products
	always_ff @(posedge clk) begin
		p_yz_s1 <= u_y * v_z;
		p_zy_s1 <= u_z * v_y;
		p_zx_s1 <= u_z * v_x;
		p_xz_s1 <= u_x * v_z;
		p_xy_s1 <= u_x * v_y;
		p_yx_s1 <= u_y * v_x;
		p_xx_s1 <= u_x * v_x;
		p_yy_s1 <= u_y * v_y;
		p_zz_s1 <= u_z * v_z;
		u_x_s1  <= u_x;
		u_y_s1  <= u_y;
		u_z_s1  <= u_z;
	end

	// rounded cross and dot
	logic signed [37:0] dx_w, dy_w, dz_w, dot_w;
	always_comb begin
		dx_w  = 38'(rav_pkg::rnd30(66'(p_yz_s1))) - 38'(rav_pkg::rnd30(66'(p_zy_s1)));
		dy_w  = 38'(rav_pkg::rnd30(66'(p_zx_s1))) - 38'(rav_pkg::rnd30(66'(p_xz_s1)));
		dz_w  = 38'(rav_pkg::rnd30(66'(p_xy_s1))) - 38'(rav_pkg::rnd30(66'(p_yx_s1)));
		dot_w = 38'(rav_pkg::rnd30(66'(p_xx_s1))) + 38'(rav_pkg::rnd30(66'(p_yy_s1)))
		      + 38'(rav_pkg::rnd30(66'(p_zz_s1)));
	end

	always_ff @(posedge clk) begin
		c_x_s2 <= rav_pkg::sat32(dx_w);
		c_y_s2 <= rav_pkg::sat32(dy_w);
		c_z_s2 <= rav_pkg::sat32(dz_w);
		if (dot_w > 38'sd1073741824) begin
			cos_s2 <= rav_pkg::ONE_Q30;
		end else if (dot_w < -38'sd1073741824) begin
			cos_s2 <= -rav_pkg::ONE_Q30;
		end else begin
			cos_s2 <= signed'(dot_w[31:0]);
		end
		u_x_s2 <= u_x_s1;
		u_y_s2 <= u_y_s1;
		u_z_s2 <= u_z_s1;
	end

	// axis choice: cross product, or u crossed with x or y
	logic               nz_w;
	logic signed [32:0] abs_ux_w;
	always_comb begin
		nz_w     = (c_x_s2 != 32'sd0) || (c_y_s2 != 32'sd0) || (c_z_s2 != 32'sd0);
		abs_ux_w = u_x_s2[31] ? -33'(u_x_s2) : 33'(u_x_s2);
	end

	always_ff @(posedge clk) begin
		if (nz_w) begin
			a_x_s3 <= 33'(c_x_s2);
			a_y_s3 <= 33'(c_y_s2);
			a_z_s3 <= 33'(c_z_s2);
		end else if (abs_ux_w < rav_pkg::NINE_TENTHS_Q30) begin
			a_x_s3 <= 33'sd0;
			a_y_s3 <= 33'(u_z_s2);
			a_z_s3 <= -33'(u_y_s2);
		end else begin
			a_x_s3 <= -33'(u_z_s2);
			a_y_s3 <= 33'sd0;
			a_z_s3 <= 33'(u_x_s2);
		end
		nz_s3   <= nz_w;
		cpos_s3 <= cos_s2 > 32'sd0;
		cos_s3  <= cos_s2;
	end

	// squares of the axis
	logic signed [65:0] qx_w, qy_w, qz_w;
	always_comb begin
		qx_w = a_x_s3 * a_x_s3;
		qy_w = a_y_s3 * a_y_s3;
		qz_w = a_z_s3 * a_z_s3;
	end

	always_ff @(posedge clk) begin
		sq_x_s4 <= qx_w[63:0];
		sq_y_s4 <= qy_w[63:0];
		sq_z_s4 <= qz_w[63:0];
		a_x_s4  <= a_x_s3;
		a_y_s4  <= a_y_s3;
		a_z_s4  <= a_z_s3;
		nz_s4   <= nz_s3;
		cpos_s4 <= cpos_s3;
		cos_s4  <= cos_s3;
	end

	logic [63:0] sum_w;
	assign sum_w = sq_x_s4 + sq_y_s4 + sq_z_s4;

	always_ff @(posedge clk) begin
		item_s5.a_x <= a_x_s4;
		item_s5.a_y <= a_y_s4;
		item_s5.a_z <= a_z_s4;
		item_s5.sum <= sum_w;
		if (nz_s4) begin
			item_s5.kase <= rav_pkg::CASE_GENERAL;
			item_s5.cosv <= cos_s4;
		end else if (cpos_s4 || (sum_w == 64'd0)) begin
			item_s5.kase <= rav_pkg::CASE_IDENTITY;
			item_s5.cosv <= cos_s4;
		end else begin
			item_s5.kase <= rav_pkg::CASE_HALF_TURN;
			item_s5.cosv <= -rav_pkg::ONE_Q30;
		end
	end

	assign out_valid = vld_s5;
	assign out_item  = item_s5;

endmodule
`default_nettype wire

>>> rtl/rav_queue.sv
// two-entry queue between front and back
`default_nettype none
module rav_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  rav_pkg::axis_item_t       push_item,
	output logic                      pop_valid,
	output rav_pkg::axis_item_t       pop_item,
	output rav_pkg::queue_status_t    status
);

	rav_pkg::axis_item_t mem_q [0:1];
	rav_pkg::axis_item_t out_item_q;
	logic                wr_ptr_q, rd_ptr_q, out_valid_q;
	logic [1:0]          count_q;
	logic                pop, push_ok;

	assign pop     = count_q != 2'd0;
	assign push_ok = push && (count_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			count_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q     <= count_q + 2'(push_ok) - 2'(pop);
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_item;
		end
		if (pop) begin
			out_item_q <= mem_q[rd_ptr_q];
		end
	end

	assign pop_valid    = out_valid_q;
	assign pop_item     = out_item_q;
	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;

endmodule
`default_nettype wire

>>> rtl/rav_div.sv
// pipelined restoring divider, one quotient bit per stage, rounded numerator given
`default_nettype none
module rav_div (
	input  wire logic               clk,
	input  wire logic [61:0]        num,
	input  wire logic [31:0]        den,
	input  wire logic               neg,
	output logic signed [31:0]      q
);

	logic [61:0] rem_q [0:31];
	logic [31:0] den_q [0:31];
	logic [30:0] qt_q  [0:31];
	logic        neg_q [0:31];

	always_ff @(posedge clk) begin
		rem_q[0] <= num;
		den_q[0] <= den;
		qt_q[0]  <= 31'd0;
		neg_q[0] <= neg;
	end

	for (genvar k = 0; k < 31; k++) begin : g_stage
		logic [61:0] sh;
		logic        geq;
		assign sh  = 62'(den_q[k]) << (30 - k);
		assign geq = rem_q[k] >= sh;
		always_ff @(posedge clk) begin
			rem_q[k+1] <= geq ? rem_q[k] - sh : rem_q[k];
			qt_q[k+1]  <= geq ? (qt_q[k] | (31'd1 << (30 - k))) : qt_q[k];
			den_q[k+1] <= den_q[k];
			neg_q[k+1] <= neg_q[k];
		end
	end

	assign q = neg_q[31] ? -signed'(32'(qt_q[31])) : signed'(32'(qt_q[31]));

endmodule
`default_nettype wire

>>> rtl/rav_back.sv
// back part: axis length, normalisation and rodrigues matrix
`default_nettype none
module rav_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  rav_pkg::axis_item_t       in_item,
	output logic                      done,
	output logic signed [31:0]        rot_r0_c0,
	output logic signed [31:0]        rot_r1_c0,
	output logic signed [31:0]        rot_r2_c0,
	output logic signed [31:0]        rot_r0_c1,
	output logic signed [31:0]        rot_r1_c1,
	output logic signed [31:0]        rot_r2_c1,
	output logic signed [31:0]        rot_r0_c2,
	output logic signed [31:0]        rot_r1_c2,
	output logic signed [31:0]        rot_r2_c2,
	output logic [1:0]                align_case
);

	// square root, two radicand bits per stage
	logic [32:0]         sq_vld_q;
	logic [32:0]         sq_rem_q  [0:32];
	logic [31:0]         sq_root_q [0:32];
	logic [63:0]         sq_x_q    [0:32];
	rav_pkg::axis_item_t sq_item_q [0:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_q <= '0;
		end else begin
			sq_vld_q <= {sq_vld_q[31:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_q[0]  <= 33'd0;
		sq_root_q[0] <= 32'd0;
		sq_x_q[0]    <= in_item.sum;
		sq_item_q[0] <= in_item;
	end

	for (genvar i = 0; i < 32; i++) begin : g_sqrt
		logic [34:0] rin;
		logic [34:0] trial;
		logic        geq;
		assign rin   = {sq_rem_q[i], sq_x_q[i][63:62]};
		assign trial = {1'b0, sq_root_q[i], 2'b01};
		assign geq   = rin >= trial;
		always_ff @(posedge clk) begin
			sq_rem_q[i+1]  <= geq ? 33'(rin - trial) : rin[32:0];
			sq_root_q[i+1] <= {sq_root_q[i][30:0], geq};
			sq_x_q[i+1]    <= {sq_x_q[i][61:0], 2'b00};
			sq_item_q[i+1] <= sq_item_q[i];
		end
	end

	// numerator with half divisor for rounding, sine
	logic [31:0]         len_w;
	logic [32:0]         mx_w, my_w, mz_w;
	logic [61:0]         num_x_q, num_y_q, num_z_q;
	logic [31:0]         den_q;
	logic                neg_x_q, neg_y_q, neg_z_q, pr_vld_q;
	logic signed [31:0]  sin_q;
	rav_pkg::axis_item_t pr_item_q;

	always_comb begin
		len_w = sq_root_q[32];
		mx_w  = sq_item_q[32].a_x[32] ? 33'(-sq_item_q[32].a_x) : 33'(sq_item_q[32].a_x);
		my_w  = sq_item_q[32].a_y[32] ? 33'(-sq_item_q[32].a_y) : 33'(sq_item_q[32].a_y);
		mz_w  = sq_item_q[32].a_z[32] ? 33'(-sq_item_q[32].a_z) : 33'(sq_item_q[32].a_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_vld_q <= 1'b0;
		end else begin
			pr_vld_q <= sq_vld_q[32];
		end
	end

	always_ff @(posedge clk) begin
		num_x_q   <= {mx_w[31:0], 30'd0} + 62'(len_w >> 1);
		num_y_q   <= {my_w[31:0], 30'd0} + 62'(len_w >> 1);
		num_z_q   <= {mz_w[31:0], 30'd0} + 62'(len_w >> 1);
		neg_x_q   <= sq_item_q[32].a_x[32];
		neg_y_q   <= sq_item_q[32].a_y[32];
		neg_z_q   <= sq_item_q[32].a_z[32];
		den_q     <= len_w;
		pr_item_q <= sq_item_q[32];
		if (sq_item_q[32].kase != rav_pkg::CASE_GENERAL) begin
			sin_q <= 32'sd0;
		end else if (len_w > rav_pkg::ONE_Q30_U) begin
			sin_q <= rav_pkg::ONE_Q30;
		end else begin
			sin_q <= signed'(len_w);
		end
	end

	logic signed [31:0] k_x, k_y, k_z;

	rav_div u_div_x (.clk(clk), .num(num_x_q), .den(den_q), .neg(neg_x_q), .q(k_x));
	rav_div u_div_y (.clk(clk), .num(num_y_q), .den(den_q), .neg(neg_y_q), .q(k_y));
	rav_div u_div_z (.clk(clk), .num(num_z_q), .den(den_q), .neg(neg_z_q), .q(k_z));

	// delay line matching the dividers
	logic [31:0]         dl_vld_q;
	logic signed [31:0]  dl_sin_q  [0:31];
	logic signed [31:0]  dl_cos_q  [0:31];
	rav_pkg::align_case_t dl_kase_q [0:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_vld_q <= '0;
		end else begin
			dl_vld_q <= {dl_vld_q[30:0], pr_vld_q};
		end
	end

	always_ff @(posedge clk) begin
		dl_sin_q[0]  <= sin_q;
		dl_cos_q[0]  <= pr_item_q.cosv;
		dl_kase_q[0] <= pr_item_q.kase;
	end

	for (genvar j = 0; j < 31; j++) begin : g_dly
		always_ff @(posedge clk) begin
			dl_sin_q[j+1]  <= dl_sin_q[j];
			dl_cos_q[j+1]  <= dl_cos_q[j];
			dl_kase_q[j+1] <= dl_kase_q[j];
		end
	end

	// matrix stages
	logic                 vld_s1, vld_s2, vld_s3, done_q;
	logic signed [63:0]   kxx_s1, kxy_s1, kxz_s1, kyy_s1, kyz_s1, kzz_s1;
	logic signed [63:0]   ksx_s1, ksy_s1, ksz_s1;
	logic signed [32:0]   ic_s1, ic_s2;
	logic signed [31:0]   cos_s1, cos_s2, cos_s3;
	rav_pkg::align_case_t kase_s1, kase_s2, kase_s3, kase_q;

	logic signed [31:0]   rxx_s2, rxy_s2, rxz_s2, ryy_s2, ryz_s2, rzz_s2;
	logic signed [31:0]   rsx_s2, rsy_s2, rsz_s2, rsx_s3, rsy_s3, rsz_s3;
	logic signed [64:0]   pxx_s3, pxy_s3, pxz_s3, pyy_s3, pyz_s3, pzz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= dl_vld_q[31];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		kxx_s1  <= k_x * k_x;
		kxy_s1  <= k_x * k_y;
		kxz_s1  <= k_x * k_z;
		kyy_s1  <= k_y * k_y;
		kyz_s1  <= k_y * k_z;
		kzz_s1  <= k_z * k_z;
		ksx_s1  <= k_x * dl_sin_q[31];
		ksy_s1  <= k_y * dl_sin_q[31];
		ksz_s1  <= k_z * dl_sin_q[31];
		ic_s1   <= 33'(rav_pkg::ONE_Q30) - 33'(dl_cos_q[31]);
		cos_s1  <= dl_cos_q[31];
		kase_s1 <= dl_kase_q[31];
	end

	always_ff @(posedge clk) begin
		rxx_s2  <= 32'(rav_pkg::rnd30(66'(kxx_s1)));
		rxy_s2  <= 32'(rav_pkg::rnd30(66'(kxy_s1)));
		rxz_s2  <= 32'(rav_pkg::rnd30(66'(kxz_s1)));
		ryy_s2  <= 32'(rav_pkg::rnd30(66'(kyy_s1)));
		ryz_s2  <= 32'(rav_pkg::rnd30(66'(kyz_s1)));
		rzz_s2  <= 32'(rav_pkg::rnd30(66'(kzz_s1)));
		rsx_s2  <= 32'(rav_pkg::rnd30(66'(ksx_s1)));
		rsy_s2  <= 32'(rav_pkg::rnd30(66'(ksy_s1)));
		rsz_s2  <= 32'(rav_pkg::rnd30(66'(ksz_s1)));
		ic_s2   <= ic_s1;
		cos_s2  <= cos_s1;
		kase_s2 <= kase_s1;
	end

	logic signed [64:0] mxx_w, mxy_w, mxz_w, myy_w, myz_w, mzz_w;
	always_comb begin
		mxx_w = rxx_s2 * ic_s2;
		mxy_w = rxy_s2 * ic_s2;
		mxz_w = rxz_s2 * ic_s2;
		myy_w = ryy_s2 * ic_s2;
		myz_w = ryz_s2 * ic_s2;
		mzz_w = rzz_s2 * ic_s2;
	end

	always_ff @(posedge clk) begin
		pxx_s3  <= mxx_w;
		pxy_s3  <= mxy_w;
		pxz_s3  <= mxz_w;
		pyy_s3  <= myy_w;
		pyz_s3  <= myz_w;
		pzz_s3  <= mzz_w;
		rsx_s3  <= rsx_s2;
		rsy_s3  <= rsy_s2;
		rsz_s3  <= rsz_s2;
		cos_s3  <= cos_s2;
		kase_s3 <= kase_s2;
	end

	logic signed [37:0] txx_w, txy_w, txz_w, tyy_w, tyz_w, tzz_w;
	logic signed [37:0] c_w, sx_w, sy_w, sz_w;
	always_comb begin
		txx_w = 38'(rav_pkg::rnd30(66'(pxx_s3)));
		txy_w = 38'(rav_pkg::rnd30(66'(pxy_s3)));
		txz_w = 38'(rav_pkg::rnd30(66'(pxz_s3)));
		tyy_w = 38'(rav_pkg::rnd30(66'(pyy_s3)));
		tyz_w = 38'(rav_pkg::rnd30(66'(pyz_s3)));
		tzz_w = 38'(rav_pkg::rnd30(66'(pzz_s3)));
		c_w   = 38'(cos_s3);
		sx_w  = 38'(rsx_s3);
		sy_w  = 38'(rsy_s3);
		sz_w  = 38'(rsz_s3);
	end

	always_ff @(posedge clk) begin
		kase_q <= kase_s3;
		if (kase_s3 == rav_pkg::CASE_IDENTITY) begin
			rot_r0_c0 <= rav_pkg::ONE_Q30;
			rot_r1_c0 <= 32'sd0;
			rot_r2_c0 <= 32'sd0;
			rot_r0_c1 <= 32'sd0;
			rot_r1_c1 <= rav_pkg::ONE_Q30;
			rot_r2_c1 <= 32'sd0;
			rot_r0_c2 <= 32'sd0;
			rot_r1_c2 <= 32'sd0;
			rot_r2_c2 <= rav_pkg::ONE_Q30;
		end else begin
			rot_r0_c0 <= rav_pkg::sat32(c_w + txx_w);
			rot_r1_c0 <= rav_pkg::sat32(txy_w + sz_w);
			rot_r2_c0 <= rav_pkg::sat32(txz_w - sy_w);
			rot_r0_c1 <= rav_pkg::sat32(txy_w - sz_w);
			rot_r1_c1 <= rav_pkg::sat32(c_w + tyy_w);
			rot_r2_c1 <= rav_pkg::sat32(tyz_w + sx_w);
			rot_r0_c2 <= rav_pkg::sat32(txz_w + sy_w);
			rot_r1_c2 <= rav_pkg::sat32(tyz_w - sx_w);
			rot_r2_c2 <= rav_pkg::sat32(c_w + tzz_w);
		end
	end

	assign done       = done_q;
	assign align_case = kase_q;

endmodule
`default_nettype wire

>>> rtl/rotation_align_vectors_unit.sv
// top level of the rotation align unit: front, queue and back joined
// the path from accept to done holds 77 register stages (5 front, 2 queue, 70 back)
// throughput: one request per cycle; the 33-stage square root and the three
//   32-stage dividers are fully pipelined, every stage takes a new request each cycle
// done marks each result for one cycle; the receiver cannot stall
// reset: arst_n clears all valid bits and the queue at once; no clearing pass
`default_nettype none
module rotation_align_vectors_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] u_x,
	input  wire logic signed [31:0] u_y,
	input  wire logic signed [31:0] u_z,
	input  wire logic signed [31:0] v_x,
	input  wire logic signed [31:0] v_y,
	input  wire logic signed [31:0] v_z,
	output logic                    done,
	output logic signed [31:0]      rot_r0_c0,
	output logic signed [31:0]      rot_r1_c0,
	output logic signed [31:0]      rot_r2_c0,
	output logic signed [31:0]      rot_r0_c1,
	output logic signed [31:0]      rot_r1_c1,
	output logic signed [31:0]      rot_r2_c1,
	output logic signed [31:0]      rot_r0_c2,
	output logic signed [31:0]      rot_r1_c2,
	output logic signed [31:0]      rot_r2_c2,
	output logic [1:0]              align_case
);

	// request taken whenever the queue has room
	logic                   take;
	logic                   fr_valid, bk_valid;
	rav_pkg::axis_item_t    fr_item, bk_item;
	rav_pkg::queue_status_t q_status;

	assign take = start && !busy;

	// front: products, case decision and squared axis length
	rav_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take),
		.u_x(u_x), .u_y(u_y), .u_z(u_z),
		.v_x(v_x), .v_y(v_y), .v_z(v_z),
		.out_valid(fr_valid), .out_item(fr_item)
	);

	// queue drains every cycle, so it never fills while the back runs
	rav_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(fr_valid), .push_item(fr_item),
		.pop_valid(bk_valid), .pop_item(bk_item),
		.status(q_status)
	);

	assign busy = q_status.full;

	// back: square root, normalisation, matrix entries
	rav_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(bk_valid), .in_item(bk_item),
		.done(done),
		.rot_r0_c0(rot_r0_c0), .rot_r1_c0(rot_r1_c0), .rot_r2_c0(rot_r2_c0),
		.rot_r0_c1(rot_r0_c1), .rot_r1_c1(rot_r1_c1), .rot_r2_c1(rot_r2_c1),
		.rot_r0_c2(rot_r0_c2), .rot_r1_c2(rot_r1_c2), .rot_r2_c2(rot_r2_c2),
		.align_case(align_case)
	);

endmodule
`default_nettype wire

>>> rtl/rav_checker.sv
// port-level assertions for the rotation align unit, with bind
`default_nettype none
module rav_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic signed [31:0] u_x,
	input wire logic signed [31:0] u_y,
	input wire logic signed [31:0] u_z,
	input wire logic signed [31:0] v_x,
	input wire logic signed [31:0] v_y,
	input wire logic signed [31:0] v_z,
	input wire logic               done,
	input wire logic signed [31:0] rot_r0_c0,
	input wire logic signed [31:0] rot_r1_c0,
	input wire logic signed [31:0] rot_r2_c0,
	input wire logic signed [31:0] rot_r0_c1,
	input wire logic signed [31:0] rot_r1_c1,
	input wire logic signed [31:0] rot_r2_c1,
	input wire logic signed [31:0] rot_r0_c2,
	input wire logic signed [31:0] rot_r1_c2,
	input wire logic signed [31:0] rot_r2_c2,
	input wire logic [1:0]         align_case
);

	// the back never stalls, so requests are never held off
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_no_done_in_reset: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("done during reset");

	a_case_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (align_case == rav_pkg::CASE_GENERAL || align_case == rav_pkg::CASE_IDENTITY
		          || align_case == rav_pkg::CASE_HALF_TURN))
		else $error("undefined case code");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && align_case == rav_pkg::CASE_IDENTITY) |->
		(rot_r0_c0 == rav_pkg::ONE_Q30 && rot_r1_c1 == rav_pkg::ONE_Q30
		 && rot_r2_c2 == rav_pkg::ONE_Q30 && rot_r1_c0 == 32'sd0 && rot_r2_c0 == 32'sd0
		 && rot_r0_c1 == 32'sd0 && rot_r2_c1 == 32'sd0 && rot_r0_c2 == 32'sd0
		 && rot_r1_c2 == 32'sd0))
		else $error("identity result wrong");

	// half turn has no sine term, so the matrix is symmetric
	a_half_turn_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(done && align_case == rav_pkg::CASE_HALF_TURN) |->
		(rot_r1_c0 == rot_r0_c1 && rot_r2_c0 == rot_r0_c2 && rot_r2_c1 == rot_r1_c2))
		else $error("half turn not symmetric");

endmodule

bind rotation_align_vectors_unit rav_checker u_rav_checker (.*);
`default_nettype wire
